// File: hdl/button_debounce_press_counter_macros.svh
// Assertion macros shared by the button debounce press counter modules.
`ifndef BUTTON_DEBOUNCE_PRESS_COUNTER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BDPC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BDPC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bdpc_pkg.sv
// Types and constants of the button debounce press counter.
package bdpc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int COUNT_W = 8;
    localparam int IDX_W   = 2;

    localparam logic [CFG_W-1:0]   DEBOUNCE_RESET = 16'd10;
    localparam logic [CFG_W-1:0]   SHORT_RESET    = 16'd1000;
    localparam logic [CFG_W-1:0]   TIMEOUT_RESET  = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

    // Input commands.
    typedef enum logic
    {
        CMD_TICK  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0]
    {
        REG_DEBOUNCE = 2'd0,
        REG_SHORT    = 2'd1,
        REG_TIMEOUT  = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] short_press_ms;
        logic [CFG_W-1:0] count_timeout_ms;
    } cfg_t;

    typedef struct packed
    {
        logic               pressed_edge;
        logic               released_edge;
        logic               steady_level;
        logic [COUNT_W-1:0] press_count;
        logic [TIME_W-1:0]  held_ms;
    } result_t;

endpackage

// File: hdl/bdpc_ifs.sv
// Valid/ready channel interfaces for input beats and result beats.
interface bdpc_item_if;
    logic valid;
    logic ready;
    logic command;
    logic level;

    modport source (output valid, output command, output level, input ready);
    modport sink   (input valid, input command, input level, output ready);
endinterface

interface bdpc_result_if;
    logic        valid;
    logic        ready;
    logic        pressed_edge;
    logic        released_edge;
    logic        steady_level;
    logic [7:0]  press_count;
    logic [31:0] held_ms;

    modport source (output valid, output pressed_edge, output released_edge,
                    output steady_level, output press_count, output held_ms,
                    input ready);
    modport sink   (input valid, input pressed_edge, input released_edge,
                    input steady_level, input press_count, input held_ms,
                    output ready);
endinterface

// File: hdl/button_debounce_press_counter.sv
// Top level of the button debouncer with short-press counter.
//
//   Channel  Dir  Handshake      Payload
//   item     in   valid/ready    command, level
//   result   out  valid/ready    pressed_edge, released_edge, steady_level,
//                                press_count, held_ms
//   wr_*     in   write enable   wr_index, wr_data (no read-back)
//
// One beat is accepted per cycle while input ready is high; its result passes
// a single logic stage into the output register, or the skid entry on a stall.
// Reset loads the register defaults and the button state (released, count 0).
// A stalled result keeps accepting one more beat into the skid entry; input
// ready then drops until the output side takes a result.
module button_debounce_press_counter
(
    input  logic                       clk,
    input  logic                       rst_n,
    bdpc_item_if.sink                  item,
    bdpc_result_if.source              result,
    input  logic                       wr_en,
    input  logic [bdpc_pkg::IDX_W-1:0] wr_index,
    input  logic [bdpc_pkg::CFG_W-1:0] wr_data
);
    import bdpc_pkg::*;

    cfg_t    cfg;
    result_t step_result;
    result_t out_data;
    logic    in_ready;
    logic    in_fire;

    assign item.ready = in_ready;
    assign in_fire    = item.valid && in_ready;

    // Configuration registers.
    bdpc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Per-beat debounce and counting logic.
    bdpc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (in_fire),
        .command (item.command),
        .level   (item.level),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Result register and skid entry.
    bdpc_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_data   (step_result),
        .in_ready  (in_ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.pressed_edge  = out_data.pressed_edge;
    assign result.released_edge = out_data.released_edge;
    assign result.steady_level  = out_data.steady_level;
    assign result.press_count   = out_data.press_count;
    assign result.held_ms       = out_data.held_ms;
endmodule

// File: hdl/bdpc_cfg.sv
// Configuration register file written through the plain write port.
module bdpc_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [bdpc_pkg::IDX_W-1:0] wr_index,
    input  logic [bdpc_pkg::CFG_W-1:0] wr_data,
    output bdpc_pkg::cfg_t             cfg
);
    import bdpc_pkg::*;

    cfg_t cfg_reg;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= DEBOUNCE_RESET;
            cfg_reg.short_press_ms   <= SHORT_RESET;
            cfg_reg.count_timeout_ms <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_DEBOUNCE: cfg_reg.debounce_ms      <= wr_data;
                REG_SHORT:    cfg_reg.short_press_ms   <= wr_data;
                REG_TIMEOUT:  cfg_reg.count_timeout_ms <= wr_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: hdl/bdpc_core.sv
// Debounce state, press timing and short-press counting for one beat.
module bdpc_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              command,
    input  logic              level,
    input  bdpc_pkg::cfg_t    cfg,
    output bdpc_pkg::result_t result
);
    import bdpc_pkg::*;

    logic [TIME_W-1:0]  now_ms_reg, now_ms_next;
    logic               last_raw_reg, last_raw_next;
    logic [TIME_W-1:0]  change_stamp_reg, change_stamp_next;
    logic               prev_steady_reg, prev_steady_next;
    logic               steady_reg, steady_next;
    logic [TIME_W-1:0]  press_stamp_reg, press_stamp_next;
    logic [COUNT_W-1:0] short_count_reg, short_count_next;

    logic               is_tick;
    logic [TIME_W-1:0]  quiet;
    logic [TIME_W-1:0]  hold_len;
    logic               settle;
    logic               timed_out;
    logic               fell;
    logic               rose;
    logic [COUNT_W-1:0] count_base;

    assign is_tick = (cmd_t'(command) == CMD_TICK);

    // Next state and result of the beat being accepted.
    always_comb
    begin
        now_ms_next       = is_tick ? now_ms_reg + 1'b1 : now_ms_reg;
        last_raw_next     = last_raw_reg;
        change_stamp_next = change_stamp_reg;
        if (is_tick && (level != last_raw_reg))
        begin
            last_raw_next     = level;
            change_stamp_next = now_ms_next;
        end

        quiet     = now_ms_next - change_stamp_next;
        settle    = is_tick && (quiet > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms});
        timed_out = is_tick && (quiet > {{(TIME_W-CFG_W){1'b0}}, cfg.count_timeout_ms});
        fell      = settle && steady_reg && !level;
        rose      = settle && !steady_reg && level;
        hold_len  = now_ms_next - press_stamp_reg;

        prev_steady_next = settle ? steady_reg : prev_steady_reg;
        steady_next      = settle ? level : steady_reg;

        // A timeout clear comes before a release on the same tick.
        count_base       = timed_out ? '0 : short_count_reg;
        short_count_next = count_base;
        press_stamp_next = press_stamp_reg;
        if (!is_tick)
        begin
            short_count_next = '0;
            if (!steady_reg)
            begin
                press_stamp_next = now_ms_reg;
            end
        end
        else if (fell)
        begin
            press_stamp_next = now_ms_next;
        end
        else if (rose && (hold_len < {{(TIME_W-CFG_W){1'b0}}, cfg.short_press_ms})
                 && (count_base != COUNT_MAX))
        begin
            short_count_next = count_base + 1'b1;
        end

        result.pressed_edge  = fell;
        result.released_edge = rose;
        result.steady_level  = steady_next;
        result.press_count   = short_count_next;
        result.held_ms       = (!prev_steady_next && !steady_next)
                             ? now_ms_next - press_stamp_next : '0;
    end

    // State advances only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reg       <= '0;
            last_raw_reg     <= 1'b1;
            change_stamp_reg <= '0;
            prev_steady_reg  <= 1'b1;
            steady_reg       <= 1'b1;
            press_stamp_reg  <= '0;
            short_count_reg  <= '0;
        end
        else if (fire)
        begin
            now_ms_reg       <= now_ms_next;
            last_raw_reg     <= last_raw_next;
            change_stamp_reg <= change_stamp_next;
            prev_steady_reg  <= prev_steady_next;
            steady_reg       <= steady_next;
            press_stamp_reg  <= press_stamp_next;
            short_count_reg  <= short_count_next;
        end
    end

`include "button_debounce_press_counter_macros.svh"

    `BDPC_ASSERT_NXT(a_clear_zeroes_count, fire && (cmd_t'(command) == CMD_CLEAR), short_count_reg == '0, "clear beat left a nonzero count")
    `BDPC_ASSERT_NXT(a_steady_holds_idle, !fire, $stable(steady_reg) && $stable(short_count_reg), "state moved without an accepted beat")
    `BDPC_ASSERT_NXT(a_tick_advances_time, fire && is_tick, now_ms_reg == $past(now_ms_reg) + 1'b1, "tick did not advance time by one")
endmodule

// File: hdl/bdpc_outbuf.sv
// Output register with a skid entry, so a stalled result does not block input until the skid entry is full.
module bdpc_outbuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  bdpc_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bdpc_pkg::result_t out_data
);
    import bdpc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !skid_valid_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload, older beat first.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (in_fire)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "button_debounce_press_counter_macros.svh"

    `BDPC_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry held with empty output register")
    `BDPC_ASSERT_NXT(a_stall_fills_skid, in_fire && out_valid_reg && !out_ready, skid_valid_reg, "beat lost while output stalled")
    `BDPC_ASSERT_NXT(a_skid_drains, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg, "skid entry did not move to output")
endmodule
